>>> sv/ftanh_pkg.sv
package ftanh_pkg;

  // range selection and index forming
  localparam logic [31:0] IdxBias  = 32'h39800000;
  localparam logic [31:0] LinBound = 32'h39ddb3d7;
  localparam logic [31:0] SatBound = 32'h41102cb3;
  localparam logic [31:0] OneBits  = 32'h3f800000;
  localparam int          IdxShift = 22;

  // per-item data that travels beside the arithmetic
  typedef struct packed {
    logic [4:0]         idx;   // interval index
    logic [23:0]        rm;    // reduced argument, normalized mantissa
    logic signed [10:0] re;    // reduced argument exponent (value = rm * 2^(re-150))
    logic               sgn;   // input sign
    logic [30:0]        mag;   // input magnitude bits
    logic               last;
  } side_t;

  // coefficient ROM, row k holds c_k for all 32 intervals
  localparam logic [31:0] CoefRom [7][32] = '{
    '{32'h00000000,32'h39bfffff,32'h39ffffff,32'h3a3ffffe,32'h3a7ffffb,32'h3abffff7,
      32'h3affffeb,32'h3b3fffdc,32'h3b7fffab,32'h3bbfff70,32'h3bfffeab,32'h3c3ffdc0,
      32'h3c7ffaab,32'h3cbff701,32'h3cffeaad,32'h3d3fdc08,32'h3d7faacd,32'h3dbf7081,
      32'h3dfeacc9,32'h3e3dc7fd,32'h3e7acbf5,32'h3eb77a9f,32'h3eec9a9f,32'h3f22991f,
      32'h3f42f7d6,32'h3f67b7cc,32'h3f76ca83,32'h3f7ebbe9,32'h3f7fd40c,32'h3f7fff32,
      32'h3f7ffffc,32'h3f800000},
    '{32'h3f800000,32'h3f800018,32'h3f7fffe8,32'h3f7fffda,32'h3f7fffdc,32'h3f7fffdc,
      32'h3f7fffac,32'h3f7fff70,32'h3f7ffeec,32'h3f7ffdc0,32'h3f7ffbed,32'h3f7ff704,
      32'h3f7feff5,32'h3f7fdbca,32'h3f7fbfff,32'h3f7f7041,32'h3f7f009b,32'h3f7dc36c,
      32'h3f7c0aa8,32'h3f7734b8,32'h3f70a4de,32'h3f5f1fd8,32'h3f495493,32'h3f18b9ec,
      32'h3ed706cb,32'h3e390b06,32'h3d90b11f,32'h3c21a053,32'h3aaf7fdb,32'h37ccc1a3,
      32'h355c6733,32'h00000000},
    '{32'h00000000,32'hbe4e0ff1,32'h3d25b1b1,32'h3d6b6dab,32'h3c9fb1d5,32'hbabff06f,
      32'h3c07b3f6,32'hbb3fc1bc,32'h3a9f5921,32'hbbbf06f2,32'hbbb0f402,32'hbc47db9e,
      32'hbc73d5e7,32'hbca25bda,32'hbcfca780,32'hbd40e07c,32'hbd7dab03,32'hbdbe4a0f,
      32'hbdfb14a5,32'hbe36cc8d,32'hbe6bd102,32'hbe9fe7c5,32'hbeba0f10,32'hbec206a8,
      32'hbea3c388,32'hbe277d62,32'hbd8b7960,32'hbc209f49,32'hbaad44ca,32'hb7c6eeac,
      32'hb663aa41,32'h00000000},
    '{32'h00000000,32'h45b3ae96,32'hc414eb20,32'hc450e02e,32'hc3152b4e,32'hbead2f56,
      32'hc2162e02,32'hbeb4bd5a,32'hc11a59a4,32'hbed2f507,32'hc020d32c,32'h3dd0f506,
      32'hbf2a75e2,32'hbff950e3,32'hbed47334,32'hbe809b8c,32'hbeb64532,32'hbe961a5b,
      32'hbe9b63ac,32'hbea0d4b2,32'hbe828a77,32'hbe378612,32'hbdc20908,32'h3d2d3957,
      32'h3dd46e89,32'h3db3f629,32'h3d2c5e7b,32'h3bd20403,32'h3a59dfae,32'h3770af45,
      32'h372cc014,32'h00000000},
    '{32'h00000000,32'hcc981a1b,32'h4a7edd3d,32'h4ab1007c,32'h48fedd9c,32'h41a557b5,
      32'h477ee32a,32'h422557f5,32'h45ff3ce4,32'h42a55641,32'h446e0867,32'hc33dc19a,
      32'h42915214,32'h43af4fad,32'h4110fe88,32'hc1099b75,32'h3fc8a8dc,32'hbfbeaef5,
      32'hbe365aad,32'h3f4d9652,32'h3ddfa08f,32'h3e34e9b8,32'h3e2d07a6,32'h3dc63567,
      32'h3cdaeb78,32'hbcd17537,32'hbc92829c,32'hbb43ab99,32'hb9b471dd,32'hb6baad5a,
      32'hb78bafc7,32'h00000000},
    '{32'h00000000,32'h52f688d5,32'hd0505c72,32'hd08f98e3,32'hce505cc9,32'hc7162b8a,
      32'hcc5061d6,32'hc7162bdf,32'hca50b37f,32'hc7162a3a,32'hc8422086,32'h471a714e,
      32'hc5ece1f1,32'hc70e3d90,32'hc3eba94a,32'h43e0c424,32'hc21f4552,32'h42217cc8,
      32'h405e7dc4,32'hc10dd401,32'h3e96b602,32'hbd1a6d2f,32'hbd393883,32'hbd674682,
      32'hbd310016,32'hb961e269,32'h3ba32495,32'h3a7680d5,32'h38b3173c,32'h35a9deea,
      32'h375c3f2a,32'h00000000},
    '{32'h00000000,32'hd8995ed1,32'h558285ea,32'h55b2cd69,32'h53028625,32'h4bc9991f,
      32'h5082898a,32'h4b4999b3,32'h4e02c07c,32'h4ac99764,32'h4b72c822,32'hca40c0e1,
      32'h489413e4,32'h49b12224,32'h46134c4e,32'hc60c2d57,32'h43c83910,32'hc3c872d1,
      32'hc186bc9e,32'h42325bc3,32'hbf2ffa4a,32'h3d9a203c,32'hbc545a43,32'hbae08fee,
      32'h3c80225d,32'h3b1fd1df,32'hba36b9d1,32'hb91de544,32'hb71f100f,32'hb408e2ed,
      32'hb685fec8,32'h00000000}
  };

  // leading zero count of a 24-bit mantissa, 24 when zero
  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n     = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 5'(23 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

>>> sv/ftanh_front.sv
// Input stage: magnitude, interval index and normalized reduced argument.
module ftanh_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [31:0]         x_bits,
  input  logic                last_item,
  output logic                out_valid,
  output ftanh_pkg::side_t    out_side
);

  logic [31:0] diff;
  logic [23:0] q;
  logic [4:0]  lz;

  // index uses a wrapping subtract of the bias
  assign diff = {1'b0, x_bits[30:0]} - ftanh_pkg::IdxBias;
  // reduced argument is the low 22 mantissa bits at the input's scale
  assign q    = {2'b00, x_bits[21:0]};
  assign lz   = ftanh_pkg::lzc24(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_side.idx  <= diff[ftanh_pkg::IdxShift +: 5];
      out_side.rm   <= q << lz;
      out_side.re   <= $signed({3'b000, x_bits[30:23]}) - $signed({6'b000000, lz});
      out_side.sgn  <= x_bits[31];
      out_side.mag  <= x_bits[30:0];
      out_side.last <= last_item;
    end
  end

endmodule

>>> sv/ftanh_fma.sv
// Five-stage fp32 fused multiply-add: p = a * r + c, round to nearest even.
// r comes pre-normalized in the side data.
module ftanh_fma (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [31:0]         in_a,
  input  logic [31:0]         in_c,
  input  ftanh_pkg::side_t    in_side,
  output logic                out_valid,
  output logic [31:0]         out_p,
  output ftanh_pkg::side_t    out_side
);

  function automatic logic [6:0] lead78(input logic [77:0] v);
    logic [6:0] n;
    logic       found;
    n     = 7'd0;
    found = 1'b0;
    for (int i = 77; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 7'(i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // ---------------- stage 1: unpack and normalize a, c
  logic [7:0]  a_ef, c_ef;
  logic [23:0] a_m, c_m;
  logic [4:0]  a_lz, c_lz;

  assign a_ef = in_a[30:23];
  assign c_ef = in_c[30:23];
  assign a_m  = {|a_ef, in_a[22:0]};
  assign c_m  = {|c_ef, in_c[22:0]};
  assign a_lz = ftanh_pkg::lzc24(a_m);
  assign c_lz = ftanh_pkg::lzc24(c_m);

  logic               s1_v;
  logic [23:0]        s1_am, s1_cm;
  logic signed [10:0] s1_ae, s1_ce;
  logic               s1_as, s1_cs, s1_az, s1_cz;
  ftanh_pkg::side_t   s1_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_am   <= a_m << a_lz;
      s1_cm   <= c_m << c_lz;
      s1_ae   <= $signed({3'b000, (a_ef == 8'd0) ? 8'd1 : a_ef}) - $signed({6'b0, a_lz});
      s1_ce   <= $signed({3'b000, (c_ef == 8'd0) ? 8'd1 : c_ef}) - $signed({6'b0, c_lz});
      s1_as   <= in_a[31];
      s1_cs   <= in_c[31];
      s1_az   <= (a_m == 24'd0);
      s1_cz   <= (c_m == 24'd0);
      s1_side <= in_side;
    end
  end

  // ---------------- stage 2: exact product
  logic               s2_v;
  logic [47:0]        s2_prod;
  logic signed [10:0] s2_pe, s2_ce;
  logic               s2_ps, s2_pz, s2_cs, s2_cz;
  logic [23:0]        s2_cm;
  ftanh_pkg::side_t   s2_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_prod <= s1_am * s1_side.rm;
      s2_pe   <= s1_ae + s1_side.re - 11'sd127;
      s2_ps   <= s1_as;
      s2_pz   <= s1_az | (s1_side.rm == 24'd0);
      s2_cm   <= s1_cm;
      s2_ce   <= s1_ce;
      s2_cs   <= s1_cs;
      s2_cz   <= s1_cz;
      s2_side <= s1_side;
    end
  end

  // ---------------- stage 3: align and add (bit 0 of the sum is sticky)
  logic [47:0]        cm48, xm, ym;
  logic signed [10:0] xe;
  logic               xs, ys;
  logic signed [11:0] ediff;
  logic [11:0]        dd;
  logic [6:0]         dc;
  logic [76:0]        xw, yw0, yw;
  logic               yst;
  logic [77:0]        xe78, ye78, sum;
  logic               sum_s;

  assign cm48  = {1'b0, s2_cm, 23'd0};
  assign ediff = $signed({s2_pe[10], s2_pe}) - $signed({s2_ce[10], s2_ce});

  always_comb begin
    if (s2_pz) begin
      xm = cm48;    xe = s2_ce; xs = s2_cs; ym = s2_prod; ys = s2_ps; dd = 12'd0;
    end else if (s2_cz) begin
      xm = s2_prod; xe = s2_pe; xs = s2_ps; ym = cm48;    ys = s2_cs; dd = 12'd0;
    end else if (ediff >= 12'sd0) begin
      xm = s2_prod; xe = s2_pe; xs = s2_ps; ym = cm48;    ys = s2_cs; dd = ediff;
    end else begin
      xm = cm48;    xe = s2_ce; xs = s2_cs; ym = s2_prod; ys = s2_ps; dd = -ediff;
    end
    dc   = (dd > 12'd77) ? 7'd77 : dd[6:0];
    xw   = {1'b0, xm, 28'd0};
    yw0  = {1'b0, ym, 28'd0};
    yw   = yw0 >> dc;
    yst  = |(yw0 & ((77'd1 << dc) - 77'd1));
    xe78 = {xw, 1'b0};
    ye78 = {yw, yst};
    if (xs == ys) begin
      sum   = xe78 + ye78;
      sum_s = xs;
    end else if (xe78 >= ye78) begin
      sum   = xe78 - ye78;
      sum_s = xs;
    end else begin
      sum   = ye78 - xe78;
      sum_s = ys;
    end
    // exact zero: negative only if both addends are negative
    if (sum == 78'd0) begin
      sum_s = xs & ys;
    end
  end

  logic               s3_v;
  logic [77:0]        s3_sum;
  logic signed [10:0] s3_e;
  logic               s3_s;
  ftanh_pkg::side_t   s3_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sum  <= sum;
      s3_e    <= xe;
      s3_s    <= sum_s;
      s3_side <= s2_side;
    end
  end

  // ---------------- stage 4: leading one, exponent, shift amount
  logic [6:0]         lead;
  logic signed [11:0] be, rr12;
  logic               norm;

  always_comb begin
    lead = lead78(s3_sum);
    be   = $signed({s3_e[10], s3_e}) + $signed({5'd0, lead}) - 12'sd75;
    norm = (be >= 12'sd1);
    rr12 = norm ? $signed({5'd0, lead}) + 12'sd1 : 12'sd77 - $signed({s3_e[10], s3_e});
    if (rr12 > 12'sd156) begin
      rr12 = 12'sd156;
    end
  end

  logic               s4_v;
  logic [77:0]        s4_sum;
  logic [7:0]         s4_rr, s4_expf;
  logic               s4_ovf, s4_zero, s4_s;
  ftanh_pkg::side_t   s4_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_sum  <= s3_sum;
      s4_rr   <= rr12[7:0];
      s4_expf <= norm ? be[7:0] : 8'd0;
      s4_ovf  <= norm && (be >= 12'sd255);
      s4_zero <= (s3_sum == 78'd0);
      s4_s    <= s3_s;
      s4_side <= s3_side;
    end
  end

  // ---------------- stage 5: shift, round, pack
  logic [155:0] ext, shd;
  logic [77:0]  vv;
  logic         lost, rnd;
  logic [30:0]  pk;
  logic [31:0]  res;

  always_comb begin
    ext  = {s4_sum, 78'd0};
    shd  = ext >> s4_rr;
    lost = |(ext & ((156'd1 << s4_rr) - 156'd1));
    vv   = shd[77:0];
    rnd  = vv[53] & ((|vv[52:0]) | lost | vv[54]);
    // carry out of the fraction moves the exponent up
    pk   = {s4_expf, vv[76:54]} + {30'd0, rnd};
    if (s4_zero) begin
      res = {s4_s, 31'd0};
    end else if (s4_ovf) begin
      res = {s4_s, 8'hff, 23'd0};
    end else begin
      res = {s4_s, pk};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_p    <= res;
      out_side <= s4_side;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v      <= in_valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      s4_v      <= s3_v;
      out_valid <= s4_v;
    end
  end

endmodule

>>> sv/fp32_tanh_piecewise_poly.sv
// fp32 tanh by piecewise degree-6 polynomials.
// Input channel: in_valid / in_ready carry x_bits (fp32) and last_item.
// Output channel: out_valid / out_ready carry y_bits (fp32) and last_result.
// One result per input, in order; last_result is a copy of last_item.
// Structure: one input stage, six five-stage FMA units in a Horner chain, one
// output register. Throughput: one item per cycle while the receiver does not
// stall; the FMA chain is fully pipelined and accepts a new operand set every
// cycle while the pipeline advances.
// |x| below the linear bound returns x, at or above the saturation bound
// returns +/-1 (NaN and infinity included), otherwise the polynomial value
// of the interval with the input sign applied.
// Reset clears all valid bits; the pipeline is empty afterwards.
// When the receiver stalls, the whole pipeline holds (in_ready drops) and
// resumes without loss or repetition once the held result is transferred.
module fp32_tanh_piecewise_poly (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] x_bits,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] y_bits,
  output logic        last_result
);

  localparam int NumFma = 6;

  logic             adv;
  logic             v   [NumFma+1];
  logic [31:0]      p   [NumFma+1];
  ftanh_pkg::side_t sd  [NumFma+1];

  // whole pipeline advances unless a finished result is held
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  ftanh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .x_bits    (x_bits),
    .last_item (last_item),
    .out_valid (v[0]),
    .out_side  (sd[0])
  );

  // Horner start value is the top coefficient
  assign p[0] = ftanh_pkg::CoefRom[6][sd[0].idx];

  for (genvar j = 0; j < NumFma; j++) begin : g_fma
    localparam int K = NumFma - 1 - j;
    ftanh_fma u_fma (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (v[j]),
      .in_a      (p[j]),
      .in_c      (ftanh_pkg::CoefRom[K][sd[j].idx]),
      .in_side   (sd[j]),
      .out_valid (v[j+1]),
      .out_p     (p[j+1]),
      .out_side  (sd[j+1])
    );
  end

  // range select and sign
  logic [31:0] ysel;
  logic [31:0] fin_mag;

  assign fin_mag = {1'b0, sd[NumFma].mag};

  always_comb begin
    if (fin_mag < ftanh_pkg::LinBound) begin
      ysel = fin_mag;
    end else if (fin_mag < ftanh_pkg::SatBound) begin
      ysel = p[NumFma];
    end else begin
      ysel = ftanh_pkg::OneBits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[NumFma];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y_bits      <= {ysel[31] ^ sd[NumFma].sgn, ysel[30:0]};
      last_result <= sd[NumFma].last;
    end
  end

  // saturated inputs give exactly one in magnitude
  assert property (@(posedge clk) disable iff (rst)
    (adv && v[NumFma] && (fin_mag >= ftanh_pkg::SatBound))
      |=> (y_bits[30:0] == ftanh_pkg::OneBits[30:0]))
    else $error("saturated input did not give one");

  // tiny inputs pass through unchanged, sign included
  assert property (@(posedge clk) disable iff (rst)
    (adv && v[NumFma] && (fin_mag < ftanh_pkg::LinBound))
      |=> (y_bits == {$past(sd[NumFma].sgn), $past(sd[NumFma].mag)}))
    else $error("linear range result differs from input");

  // reset empties the output register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

>>> verif/tanh_scoreboard.sv
`timescale 1ns / 1ps

module tanh_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] x_bits,
  input  logic        last_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] y_bits,
  input  logic        last_result,
  output int          mismatches,
  output int          outstanding
);

  localparam logic [31:0] AbsMask  = 32'h7fffffff;
  localparam logic [31:0] SignMask = 32'h80000000;
  localparam logic [31:0] HiMask   = 32'hffc00000;

  typedef struct {
    logic [31:0] y;
    logic        last;
  } tanh_result_t;

  tanh_result_t tanh_expected_q[$];

  assign outstanding = tanh_expected_q.size();

  // widen an fp32 pattern to a real, subnormals included
  function automatic real sp_to_real(input logic [31:0] b);
    logic [63:0] d;
    int          ex;
    logic [23:0] fr;
    d  = {b[31], 63'd0};
    ex = int'(b[30:23]);
    fr = {1'b0, b[22:0]};
    if (ex == 255) begin
      d[62:52] = 11'h7ff;
      d[51:29] = b[22:0];
    end else if (ex != 0 || fr != 0) begin
      if (ex == 0) begin
        ex = 1;
        while (!fr[23]) begin
          fr = fr << 1;
          ex = ex - 1;
        end
      end else begin
        fr[23] = 1'b1;
      end
      d[62:52] = 11'(ex - 127 + 1023);
      d[51:29] = fr[22:0];
    end
    return $bitstoreal(d);
  endfunction

  // round a real to fp32, nearest even
  function automatic logic [31:0] real_to_sp(input real v);
    logic [63:0] d;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] res;
    int          fe;
    int          sh;
    d = $realtobits(v);
    if (d[62:52] == 0) return {d[63], 31'd0};
    if (d[62:52] == 11'h7ff) return {d[63], 8'hff, (d[51:0] != 0), 22'd0};
    m  = {11'd0, 1'b1, d[51:0]};
    fe = int'(d[62:52]) - 1023 + 127;
    sh = (fe >= 1) ? 29 : 29 + (1 - fe);
    if (sh > 60) return {d[63], 31'd0};
    q    = m >> sh;
    rem  = m & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    if (fe >= 1) res = (64'(fe) << 23) + q - (64'd1 << 23);
    else res = q;
    if (res >= 64'h7f800000) res = 64'h7f800000;
    return {d[63], res[30:0]};
  endfunction

  // a*b + c with one rounding: exact product, round-to-odd sum, then to fp32
  function automatic logic [31:0] fused_mac(input logic [31:0] a, b, c);
    real         p, cc, s, t, e;
    logic [63:0] sb;
    p  = sp_to_real(a) * sp_to_real(b);
    cc = sp_to_real(c);
    s  = p + cc;
    t  = s - p;
    e  = (p - (s - t)) + (cc - t);
    if (s - s == 0.0 && e != 0.0) begin
      sb = $realtobits(s);
      if (!sb[0]) begin
        if ((e > 0.0) == (s > 0.0)) sb = sb + 1;
        else sb = sb - 1;
        s = $bitstoreal(sb);
      end
    end
    return real_to_sp(s);
  endfunction

  function automatic logic [31:0] tanh_of(input logic [31:0] x);
    logic [31:0] mag;
    logic [31:0] seg;
    logic [4:0]  idx;
    logic [31:0] r;
    logic [31:0] acc;
    logic [31:0] y;
    mag = x & AbsMask;
    seg = (mag - ftanh_pkg::IdxBias) >> ftanh_pkg::IdxShift;
    idx = seg[4:0];
    if (mag < ftanh_pkg::LinBound) begin
      y = mag;
    end else if (mag < ftanh_pkg::SatBound) begin
      r   = real_to_sp(sp_to_real(mag) - sp_to_real(mag & HiMask));
      acc = ftanh_pkg::CoefRom[6][idx];
      for (int k = 5; k >= 0; k--) acc = fused_mac(acc, r, ftanh_pkg::CoefRom[k][idx]);
      y = acc;
    end else begin
      y = ftanh_pkg::OneBits;
    end
    return y ^ (x & SignMask);
  endfunction

  // predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    tanh_result_t want;
    if (rst) begin
      tanh_expected_q.delete();
      mismatches <= 0;
    end else begin
      if (in_valid && in_ready) begin
        want.y    = tanh_of(x_bits);
        want.last = last_item;
        tanh_expected_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (tanh_expected_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected result y=%h last=%b", y_bits, last_result);
        end else begin
          want = tanh_expected_q.pop_front();
          if (want.y !== y_bits || want.last !== last_result) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected y=%h last=%b, got y=%h last=%b",
                       want.y, want.last, y_bits, last_result);
          end
        end
      end
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] x_bits = '0;
  logic        last_item = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] y_bits;
  logic        last_result;
  int          mismatches;
  int          outstanding;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          sent = 0;

  always #4 clk = ~clk;

  fp32_tanh_piecewise_poly dut (.*);

  tanh_scoreboard chk (.*);

  // receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one input transfer, with random idle cycles first
  task automatic push_word(input logic [31:0] x, input logic lst);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    x_bits    <= x;
    last_item <= lst;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60)
      return {1'($urandom_range(1)),
              31'($urandom_range(ftanh_pkg::SatBound - 1, ftanh_pkg::LinBound))};
    if (sel < 80) return $urandom;
    if (sel < 90)
      return {1'($urandom_range(1)), 31'(ftanh_pkg::LinBound + $urandom_range(8) - 4)};
    return {1'($urandom_range(1)), 31'(ftanh_pkg::SatBound + $urandom_range(8) - 4)};
  endfunction

  logic [31:0] directed[$] = '{
    32'h00000000, 32'h80000000, 32'h00000001, 32'h807fffff, 32'h39ddb3d6,
    32'h39ddb3d7, 32'hb9ddb3d7, 32'h41102cb2, 32'hc1102cb2, 32'h41102cb3,
    32'h7f800000, 32'hff800000, 32'h7fc00000, 32'hffffffff, 32'h7f7fffff,
    32'h39800000, 32'h3f800000, 32'hbf000000, 32'h3a000000, 32'h3e7fffff,
    32'h40000000, 32'hc0a00001, 32'h3c400000, 32'h7fffffff
  };

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) push_word(directed[i], i == directed.size() - 1);
    // hold off until the pipeline is empty
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 46 : (ph == 3) ? 19 : 0;
      recv_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 19 : 0;
      for (int n = 0; n < 212; n++) push_word(pick_word(), 1'($urandom_range(1)));
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain();
    $display("%0d fp32 words sent: edge values, bounds, specials and random magnitudes,",
             sent);
    $display("under free flow, sender gaps, receiver stalls and both combined.");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
